// File: design/ftib_pkg.sv
// ftib_pkg: shared types and constants of the fan to triangle index batcher
// beat layouts, item kinds, capacity limits and the command passed front to back
// no dependencies
package ftib_pkg;

  // capacity limits of one batch
  localparam int unsigned BATCH_MAX_VERTICES = 4096;
  localparam int unsigned BATCH_MAX_INDICES  = 12288;
  localparam int unsigned MAX_POLY_VERTS     = 16;

  // state widths
  localparam int unsigned VFILL_W = 17;
  localparam int unsigned IFILL_W = 14;

  // command queue depth and pointer width
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

  // item kinds
  typedef enum logic [1:0] {
    KIND_SUBMIT = 2'd0,
    KIND_FLUSH  = 2'd1,
    KIND_BEGIN  = 2'd2,
    KIND_END    = 2'd3
  } kind_e;

  // input beat
  typedef struct packed {
    kind_e       kind;
    logic [4:0]  fan_verts;
    logic [31:0] state_key;
  } in_beat_t;

  // result beat
  typedef struct packed {
    logic               accepted;
    logic               index_valid;
    logic [15:0]        vertex_index;
    logic               last;
    logic [13:0]        batch_index_count;
    logic [31:0]        batch_key;
    logic               pending;
    logic signed [31:0] saved_draws;
    logic [31:0]        state_change_total;
  } out_beat_t;

  // command from the front to the back: a fan stream or one ready-made result
  typedef struct packed {
    logic               fan;
    logic [VFILL_W-1:0] base;
    logic [4:0]         tris;
    out_beat_t          res;
  } cmd_t;

endpackage

// File: design/ftib_front.sv
// ftib_front: accepts input beats, checks capacity and key, keeps batch state
// and statistics, and pushes one command per item into the queue
// depends on ftib_pkg
module ftib_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  ftib_pkg::in_beat_t in_beat_i,
  input  logic              q_full_i,
  output logic              q_push_o,
  output ftib_pkg::cmd_t    q_cmd_o
);
  import ftib_pkg::*;

  logic [VFILL_W-1:0] vfill_q, vfill_d;
  logic [IFILL_W-1:0] ifill_q, ifill_d;
  logic [31:0]        key_q, key_d;
  logic [31:0]        batched_q, batched_d;
  logic [31:0]        flushed_q, flushed_d;
  logic [31:0]        changes_q, changes_d;

  logic [4:0]  n;
  logic [4:0]  tris;
  logic [6:0]  need_i;
  logic        is_big, oversize, vfit, ifit, cap_ok, empty, key_mis, ok;

  assign in_ready_o = !q_full_i;
  assign q_push_o   = in_valid_i && in_ready_o;

  // capacity and key checks
  always_comb begin
    n        = in_beat_i.fan_verts;
    is_big   = n >= 5'd3;
    oversize = n > 5'(MAX_POLY_VERTS);
    tris     = n - 5'd2;
    need_i   = 7'({tris, 1'b0}) + 7'(tris);
    vfit     = (18'(vfill_q) + 18'(n)) <= 18'(BATCH_MAX_VERTICES);
    ifit     = (15'(ifill_q) + 15'(need_i)) <= 15'(BATCH_MAX_INDICES);
    cap_ok   = !oversize && (!is_big || (vfit && ifit));
    empty    = ifill_q == '0;
    key_mis  = cap_ok && !empty && (in_beat_i.state_key != key_q);
    ok       = cap_ok && !key_mis;
  end

  // command and next state
  always_comb begin
    vfill_d   = vfill_q;
    ifill_d   = ifill_q;
    key_d     = key_q;
    batched_d = batched_q;
    flushed_d = flushed_q;
    changes_d = changes_q;

    q_cmd_o          = '0;
    q_cmd_o.base     = vfill_q;
    q_cmd_o.tris     = tris;
    q_cmd_o.res.last = 1'b1;

    unique case (in_beat_i.kind)
      KIND_SUBMIT: begin
        if (cap_ok && empty) key_d = in_beat_i.state_key;
        if (key_mis) changes_d = changes_q + 32'd1;
        if (ok) begin
          batched_d            = batched_q + 32'd1;
          q_cmd_o.res.accepted = 1'b1;
          if (is_big) begin
            q_cmd_o.fan = 1'b1;
            vfill_d     = vfill_q + VFILL_W'(n);
            ifill_d     = ifill_q + IFILL_W'(need_i);
          end
        end
      end
      KIND_FLUSH: begin
        if (!empty) begin
          q_cmd_o.res.batch_index_count = ifill_q;
          q_cmd_o.res.batch_key         = key_q;
          flushed_d                     = flushed_q + 32'd1;
        end
        vfill_d = '0;
        ifill_d = '0;
      end
      KIND_BEGIN: begin
        vfill_d   = '0;
        ifill_d   = '0;
        key_d     = '0;
        batched_d = '0;
        flushed_d = '0;
        changes_d = '0;
      end
      KIND_END: begin
        if (!empty) begin
          q_cmd_o.res.pending     = 1'b1;
          q_cmd_o.res.saved_draws = batched_q - flushed_q;
        end
        q_cmd_o.res.state_change_total = changes_q;
      end
      default: ;
    endcase
  end

  // batch state and statistics
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vfill_q   <= '0;
      ifill_q   <= '0;
      key_q     <= '0;
      batched_q <= '0;
      flushed_q <= '0;
      changes_q <= '0;
    end else if (q_push_o) begin
      vfill_q   <= vfill_d;
      ifill_q   <= ifill_d;
      key_q     <= key_d;
      batched_q <= batched_d;
      flushed_q <= flushed_d;
      changes_q <= changes_d;
    end
  end

  // a batch holds vertices exactly when it holds indices
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vfill_q == '0) == (ifill_q == '0))
    else $error("vertex and index fill disagree on empty batch");

  // fills stay within capacity
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (18'(vfill_q) <= 18'(BATCH_MAX_VERTICES)) &&
    (15'(ifill_q) <= 15'(BATCH_MAX_INDICES)))
    else $error("batch fill beyond capacity");

endmodule

// File: design/ftib_queue.sv
// ftib_queue: short command queue between the front and the back
// depends on ftib_pkg
module ftib_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  ftib_pkg::cmd_t cmd_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output ftib_pkg::cmd_t head_o
);
  import ftib_pkg::*;

  cmd_t             mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wptr_q, rptr_q;
  logic [QPTR_W:0]   cnt_q;
  logic              do_pop;

  assign full_o  = cnt_q == (QPTR_W+1)'(QUEUE_DEPTH);
  assign valid_o = cnt_q != '0;
  assign head_o  = mem_q[rptr_q];
  assign do_pop  = pop_i && valid_o;

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wptr_q] <= cmd_i;
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) wptr_q <= wptr_q + QPTR_W'(1);
      if (do_pop) rptr_q <= rptr_q + QPTR_W'(1);
      cnt_q <= cnt_q + (QPTR_W+1)'(push_i) - (QPTR_W+1)'(do_pop);
    end
  end

  // never written while full
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !push_i)
    else $error("push into full command queue");

endmodule

// File: design/ftib_back.sv
// ftib_back: turns queued commands into result beats, one beat per cycle
// unless the output stalls, walking triangles and corners of a fan;
// holds the output register; depends on ftib_pkg
module ftib_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               q_valid_i,
  input  ftib_pkg::cmd_t     q_head_i,
  output logic               q_pop_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output ftib_pkg::out_beat_t out_beat_o
);
  import ftib_pkg::*;

  logic [4:0]         tri_q;
  logic [1:0]         corner_q;
  logic               out_valid_q;
  out_beat_t          out_q;

  logic               load, fan_last;
  logic [VFILL_W-1:0] off;
  out_beat_t          beat;

  assign load     = q_valid_i && (!out_valid_q || out_ready_i);
  assign fan_last = (tri_q == (q_head_i.tris - 5'd1)) && (corner_q == 2'd2);
  assign q_pop_o  = load && (!q_head_i.fan || fan_last);

  // corner index: base, base+t+1, base+t+2
  always_comb begin
    off  = (corner_q == 2'd0) ? '0 : (VFILL_W'(tri_q) + VFILL_W'(corner_q));
    beat = q_head_i.res;
    if (q_head_i.fan) begin
      beat              = '0;
      beat.accepted     = 1'b1;
      beat.index_valid  = 1'b1;
      beat.vertex_index = 16'(q_head_i.base + off);
      beat.last         = fan_last;
    end
  end

  // fan walk counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tri_q    <= '0;
      corner_q <= '0;
    end else if (load && q_head_i.fan) begin
      if (corner_q == 2'd2) begin
        corner_q <= '0;
        tri_q    <= fan_last ? 5'd0 : tri_q + 5'd1;
      end else begin
        corner_q <= corner_q + 2'd1;
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) out_q <= beat;
  end

  assign out_valid_o = out_valid_q;
  assign out_beat_o  = out_q;

  // corner counter never reaches three
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    corner_q != 2'd3)
    else $error("corner counter out of range");

  // a fan walk in progress stays within the fan's triangles
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_valid_i && q_head_i.fan) |-> (tri_q < q_head_i.tris - 5'd1 || fan_last ||
                                     tri_q == q_head_i.tris - 5'd1))
    else $error("triangle counter beyond fan");

  // a loaded index beat always reports an accepted polygon
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && q_head_i.fan) |=> (out_q.accepted && out_q.index_valid))
    else $error("index beat without accepted flag");

endmodule

// File: design/fan_to_triangle_index_batcher_unit.sv
// fan_to_triangle_index_batcher_unit: top level of the triangle fan batcher
// joins front, command queue and back; depends on ftib_pkg and the ftib modules
//
// usage
//   input channel in_valid_i/in_ready_o carries one item per beat: submit,
//   flush, begin or end. output channel out_valid_o/out_ready_i carries result
//   beats; last marks the final beat of an item.
//   the front checks an item and updates batch state in the cycle it is taken,
//   then queues one command (four entries deep). the back turns each command
//   into beats from a registered output stage.
//   the first result beat passes the queue write, then the output register,
//   before it is valid on the output channel.
//   throughput: one result beat per cycle while out_ready_i is high, set by
//   the back's single output register; an accepted fan of n vertices gives
//   3*(n-2) beats, every other item one beat.
//   the front keeps taking items while the queue has room, so a stalled
//   receiver only holds the back; once four commands wait, in_ready_o drops.
//   reset clears batch state, statistics, queue and output valid; there is no
//   clearing pass and items are taken as soon as reset is released.
module fan_to_triangle_index_batcher_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  ftib_pkg::in_beat_t  in_beat_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output ftib_pkg::out_beat_t out_beat_o
);
  import ftib_pkg::*;

  logic q_full, q_push, q_pop, q_valid;
  cmd_t q_cmd, q_head;

  // checking and batch state
  ftib_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_beat_i  (in_beat_i),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_cmd_o    (q_cmd)
  );

  // command queue
  ftib_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .cmd_i   (q_cmd),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .head_o  (q_head)
  );

  // result beat generation
  ftib_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_head_i    (q_head),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_beat_o  (out_beat_o)
  );

endmodule
